>>> sv/mpa_pkg.sv
// ----------------------------------------------------------------------------
// mpa_pkg: shared definitions for max pooling with argmax
// Capacities, register reset values and indexes, controller state encoding
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mpa_pkg;

  // Default capacities of the line store.
  localparam int MPA_ROW_CAP    = 1024;
  localparam int MPA_WINDOW_CAP = 8;

  // Widths of the configuration port and of the fixed fields.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SAMPLE_W   = 16;
  localparam int ROWS_W     = 16;
  localparam int COLS_W     = 11;
  localparam int WIN_W      = 4;
  localparam int STEP_W     = 4;
  localparam int POS_W      = 6;
  localparam int RES_COL_W  = 10;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_PLANE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_ROW = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STEP     = 4'd3;

  // Register reset values.
  localparam logic [ROWS_W-1:0] RST_ROWS_PER_PLANE  = 16'd32;
  localparam logic [COLS_W-1:0] RST_SAMPLES_PER_ROW = 11'd32;
  localparam logic [WIN_W-1:0]  RST_WINDOW_SIZE     = 4'd2;
  localparam logic [STEP_W-1:0] RST_WINDOW_STEP     = 4'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_HOLD
  } mpa_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accept;  // a sample request is taken this cycle
    logic rd;      // issue one line store read of the window scan
    logic load;    // move the finished window into the output register
  } mpa_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic hit;        // the next sample closes a window
    logic scan_last;  // the read issued now is the last of the window
    logic out_free;   // the output register can take a result this cycle
  } mpa_status_t;

endpackage

>>> sv/mpa_if.sv
// ----------------------------------------------------------------------------
// mpa_if: request channels of the max pooling block
// Sample channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface mpa_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mpa_pkg::SAMPLE_W-1:0]    sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface mpa_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mpa_pkg::SAMPLE_W-1:0]    pooled_max;
  logic        [mpa_pkg::POS_W-1:0]       winner_position;
  logic        [mpa_pkg::ROWS_W-1:0]      result_row;
  logic        [mpa_pkg::RES_COL_W-1:0]   result_col;
  logic                                   plane_end;

  modport source (output valid, output pooled_max, output winner_position,
                  output result_row, output result_col, output plane_end,
                  input ready);
  modport sink   (input valid, input pooled_max, input winner_position,
                  input result_row, input result_col, input plane_end,
                  output ready);
endinterface

>>> sv/max_pool_with_argmax.sv
// A sample that closes no window is taken while the controller is idle; one that closes a window
// is followed by its scan: acceptance, one line store read a cycle through the single read
// port, a compare step and the load of the output register.
// While an older result still waits for the sink, that load and the input stall with it.
// Synchronous reset (rst_n low) clears the counters, the state and the valid flags and loads register defaults only.
// ----------------------------------------------------------------------------
// max_pool_with_argmax: streaming 2D max pooling with argmax
// Keeps recent rows in a line store and reports each finished window's
// maximum, its position in the window and the window's pooled coordinates.
// ----------------------------------------------------------------------------
module max_pool_with_argmax #(
  parameter int ROW_CAP    = mpa_pkg::MPA_ROW_CAP,
  parameter int WINDOW_CAP = mpa_pkg::MPA_WINDOW_CAP
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0] cfg_data,
  mpa_in_if.sink                         in_ch,
  mpa_out_if.source                      out_ch
);

  mpa_pkg::mpa_cmd_t    cmd;
  mpa_pkg::mpa_status_t status;

  // Controller.
  mpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  mpa_dp #(
    .ROW_CAP    (ROW_CAP),
    .WINDOW_CAP (WINDOW_CAP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sample (in_ch.sample_value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_max   (out_ch.pooled_max),
    .out_pos   (out_ch.winner_position),
    .out_row   (out_ch.result_row),
    .out_col   (out_ch.result_col),
    .out_end   (out_ch.plane_end)
  );

endmodule

>>> sv/mpa_ram.sv
// ----------------------------------------------------------------------------
// mpa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/mpa_ctrl.sv
// ----------------------------------------------------------------------------
// mpa_ctrl: controller of the max pooling block
// Takes sample requests, runs the window scan and hands the result over.
// ----------------------------------------------------------------------------
module mpa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mpa_pkg::mpa_status_t status,
  output mpa_pkg::mpa_cmd_t    cmd
);

  mpa_pkg::mpa_state_t state_r;
  mpa_pkg::mpa_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpa_pkg::ST_IDLE: begin
        if (in_valid && status.hit) begin
          state_nxt = mpa_pkg::ST_SCAN;
        end
      end
      mpa_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_nxt = mpa_pkg::ST_LAST;
        end
      end
      mpa_pkg::ST_LAST: begin
        state_nxt = mpa_pkg::ST_HOLD;
      end
      mpa_pkg::ST_HOLD: begin
        if (status.out_free) begin
          state_nxt = mpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mpa_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd     = 1'b0;
    cmd.load   = 1'b0;
    unique case (state_r)
      mpa_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      mpa_pkg::ST_SCAN: begin
        cmd.rd = 1'b1;
      end
      mpa_pkg::ST_LAST: begin
        cmd.load = 1'b0;
      end
      mpa_pkg::ST_HOLD: begin
        cmd.load = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/mpa_dp.sv
// ----------------------------------------------------------------------------
// mpa_dp: datapath of the max pooling block
// Configuration registers, plane position counters, line store, window scan
// with running maximum, and the output register.
// ----------------------------------------------------------------------------
module mpa_dp #(
  parameter int ROW_CAP    = mpa_pkg::MPA_ROW_CAP,
  parameter int WINDOW_CAP = mpa_pkg::MPA_WINDOW_CAP
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [mpa_pkg::SAMPLE_W-1:0]   in_sample,
  input  mpa_pkg::mpa_cmd_t                     cmd,
  output mpa_pkg::mpa_status_t                  status,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mpa_pkg::SAMPLE_W-1:0]   out_max,
  output logic [mpa_pkg::POS_W-1:0]             out_pos,
  output logic [mpa_pkg::ROWS_W-1:0]            out_row,
  output logic [mpa_pkg::RES_COL_W-1:0]         out_col,
  output logic                                  out_end
);

  localparam int CW   = $clog2(ROW_CAP);
  localparam int CNTW = $clog2(ROW_CAP + 1);
  localparam int CWX  = (CNTW > mpa_pkg::COLS_W) ? CNTW : mpa_pkg::COLS_W;
  localparam int HW   = $clog2(ROW_CAP + 16);
  localparam int RHW  = mpa_pkg::ROWS_W + 1;
  localparam int SW   = $clog2(WINDOW_CAP);
  localparam int WSW  = $clog2(WINDOW_CAP + 1);
  localparam int WWX  = (WSW > mpa_pkg::WIN_W) ? WSW : mpa_pkg::WIN_W;
  localparam int PW   = $clog2(WINDOW_CAP * WINDOW_CAP);
  localparam int AW   = $clog2(ROW_CAP * WINDOW_CAP);
  localparam int SW1  = SW + 1;

  // Effective window side: zero acts as one, clamped to the store height.
  function automatic logic [WSW-1:0] win_eff(input logic [mpa_pkg::WIN_W-1:0] raw);
    logic [WWX-1:0] v;
    v = (raw == '0) ? WWX'(1) : WWX'(raw);
    if (v > WWX'(WINDOW_CAP)) begin
      v = WWX'(WINDOW_CAP);
    end
    return WSW'(v);
  endfunction

  // Configuration registers.
  logic [mpa_pkg::ROWS_W-1:0] cfg_rows_r, cfg_rows_nxt;
  logic [mpa_pkg::COLS_W-1:0] cfg_cols_r, cfg_cols_nxt;
  logic [mpa_pkg::WIN_W-1:0]  cfg_win_r,  cfg_win_nxt;
  logic [mpa_pkg::STEP_W-1:0] cfg_step_r, cfg_step_nxt;
  logic                       restart;

  // Effective sizes.
  logic [mpa_pkg::ROWS_W-1:0] h_eff;
  logic [CNTW-1:0]            w_eff;
  logic [CWX-1:0]             w_tmp;
  logic [WSW-1:0]             ws_m1;
  logic [WSW-1:0]             ws_m1_new;
  logic [mpa_pkg::STEP_W-1:0] st_eff;

  // Plane position counters.
  logic [mpa_pkg::ROWS_W-1:0] row_r, row_nxt;
  logic [CW-1:0]              col_r, col_nxt;
  logic [SW-1:0]              slot_r, slot_nxt;
  logic [RHW-1:0]             row_hit_r, row_hit_nxt;
  logic [HW-1:0]              col_hit_r, col_hit_nxt;
  logic [mpa_pkg::ROWS_W-1:0] pool_row_r, pool_row_nxt;
  logic [CW-1:0]              pool_col_r, pool_col_nxt;
  logic                       row_is_hit, col_is_hit, col_last, row_last;

  // Window description latched when a window closes.
  logic [CW-1:0]              win_left_r;
  logic [mpa_pkg::ROWS_W-1:0] win_row_r;
  logic [CW-1:0]              win_col_r;
  logic                       win_end_r;
  logic [SW1-1:0]             top_tmp;
  logic [SW-1:0]              top_slot;
  logic                       end_now;

  // Scan counters and compare stage.
  logic [SW-1:0]              sc_slot_r;
  logic [WSW-1:0]             sc_kw_r, sc_kh_r;
  logic [PW-1:0]              sc_idx_r, idx_d_r;
  logic                       rd_vld_r;
  logic [mpa_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [mpa_pkg::SAMPLE_W-1:0] best_r;
  logic [PW-1:0]              best_pos_r;

  // Line store addresses.
  logic [AW-1:0]              wr_addr, rd_addr;

  // Output register.
  logic                       out_valid_r;
  logic signed [mpa_pkg::SAMPLE_W-1:0] out_max_r;
  logic [mpa_pkg::POS_W-1:0]  out_pos_r;
  logic [mpa_pkg::ROWS_W-1:0] out_row_r;
  logic [mpa_pkg::RES_COL_W-1:0] out_col_r;
  logic                       out_end_r;

  // Register write decode; any known register restarts the plane.
  always_comb begin
    cfg_rows_nxt = cfg_rows_r;
    cfg_cols_nxt = cfg_cols_r;
    cfg_win_nxt  = cfg_win_r;
    cfg_step_nxt = cfg_step_r;
    restart      = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        mpa_pkg::CFG_ROWS_PER_PLANE: begin
          cfg_rows_nxt = cfg_data[mpa_pkg::ROWS_W-1:0];
          restart      = 1'b1;
        end
        mpa_pkg::CFG_SAMPLES_PER_ROW: begin
          cfg_cols_nxt = cfg_data[mpa_pkg::COLS_W-1:0];
          restart      = 1'b1;
        end
        mpa_pkg::CFG_WINDOW_SIZE: begin
          cfg_win_nxt = cfg_data[mpa_pkg::WIN_W-1:0];
          restart     = 1'b1;
        end
        mpa_pkg::CFG_WINDOW_STEP: begin
          cfg_step_nxt = cfg_data[mpa_pkg::STEP_W-1:0];
          restart      = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= mpa_pkg::RST_ROWS_PER_PLANE;
      cfg_cols_r <= mpa_pkg::RST_SAMPLES_PER_ROW;
      cfg_win_r  <= mpa_pkg::RST_WINDOW_SIZE;
      cfg_step_r <= mpa_pkg::RST_WINDOW_STEP;
    end else begin
      cfg_rows_r <= cfg_rows_nxt;
      cfg_cols_r <= cfg_cols_nxt;
      cfg_win_r  <= cfg_win_nxt;
      cfg_step_r <= cfg_step_nxt;
    end
  end

  // Effective sizes from the registers.
  always_comb begin
    h_eff = (cfg_rows_r == '0) ? mpa_pkg::ROWS_W'(1) : cfg_rows_r;
    w_tmp = (cfg_cols_r == '0) ? CWX'(1) : CWX'(cfg_cols_r);
    if (w_tmp > CWX'(ROW_CAP)) begin
      w_tmp = CWX'(ROW_CAP);
    end
    w_eff     = CNTW'(w_tmp);
    ws_m1     = win_eff(cfg_win_r) - WSW'(1);
    ws_m1_new = win_eff(cfg_win_nxt) - WSW'(1);
    st_eff    = (cfg_step_r == '0) ? mpa_pkg::STEP_W'(1) : cfg_step_r;
  end

  // Window detection for the sample at the current position.
  assign row_is_hit = (RHW'(row_r) == row_hit_r);
  assign col_is_hit = (HW'(col_r) == col_hit_r);
  assign col_last   = (CNTW'(col_r) == w_eff - CNTW'(1));
  assign row_last   = (row_r == h_eff - mpa_pkg::ROWS_W'(1));

  // Top slot of the window and the last-result-of-plane flag.
  always_comb begin
    top_tmp = SW1'(slot_r) + SW1'(WINDOW_CAP) - SW1'(ws_m1);
    if (top_tmp >= SW1'(WINDOW_CAP)) begin
      top_tmp = top_tmp - SW1'(WINDOW_CAP);
    end
    top_slot = SW'(top_tmp);
    end_now  = (RHW'(row_r) + RHW'(st_eff) >= RHW'(h_eff)) &&
               (HW'(col_r) + HW'(st_eff) >= HW'(w_eff));
  end

  // Position counter update on each accepted sample and on a restart.
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    slot_nxt     = slot_r;
    row_hit_nxt  = row_hit_r;
    col_hit_nxt  = col_hit_r;
    pool_row_nxt = pool_row_r;
    pool_col_nxt = pool_col_r;
    if (restart) begin
      row_nxt      = '0;
      col_nxt      = '0;
      slot_nxt     = '0;
      row_hit_nxt  = RHW'(ws_m1_new);
      col_hit_nxt  = HW'(ws_m1_new);
      pool_row_nxt = '0;
      pool_col_nxt = '0;
    end else if (cmd.accept) begin
      if (col_last) begin
        // End of row: start the next row or the next plane.
        col_nxt      = '0;
        col_hit_nxt  = HW'(ws_m1);
        pool_col_nxt = '0;
        if (row_last) begin
          row_nxt      = '0;
          slot_nxt     = '0;
          row_hit_nxt  = RHW'(ws_m1);
          pool_row_nxt = '0;
        end else begin
          row_nxt  = row_r + mpa_pkg::ROWS_W'(1);
          slot_nxt = (slot_r == SW'(WINDOW_CAP - 1)) ? '0 : slot_r + SW'(1);
          if (row_is_hit) begin
            row_hit_nxt  = row_hit_r + RHW'(st_eff);
            pool_row_nxt = pool_row_r + mpa_pkg::ROWS_W'(1);
          end
        end
      end else begin
        col_nxt = col_r + CW'(1);
        if (col_is_hit) begin
          col_hit_nxt  = col_hit_r + HW'(st_eff);
          pool_col_nxt = pool_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      slot_r     <= '0;
      row_hit_r  <= RHW'(win_eff(mpa_pkg::RST_WINDOW_SIZE) - WSW'(1));
      col_hit_r  <= HW'(win_eff(mpa_pkg::RST_WINDOW_SIZE) - WSW'(1));
      pool_row_r <= '0;
      pool_col_r <= '0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      slot_r     <= slot_nxt;
      row_hit_r  <= row_hit_nxt;
      col_hit_r  <= col_hit_nxt;
      pool_row_r <= pool_row_nxt;
      pool_col_r <= pool_col_nxt;
    end
  end

  // Latch the window and start the scan when a sample closes a window.
  always_ff @(posedge clk) begin
    if (cmd.accept && row_is_hit && col_is_hit) begin
      win_left_r <= CW'(HW'(col_r) - HW'(ws_m1));
      win_row_r  <= pool_row_r;
      win_col_r  <= pool_col_r;
      win_end_r  <= end_now;
    end
  end

  // Scan counters: rows of the window top to bottom, columns left to right.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_slot_r <= '0;
      sc_kw_r   <= '0;
      sc_kh_r   <= '0;
      sc_idx_r  <= '0;
    end else if (cmd.accept) begin
      sc_slot_r <= top_slot;
      sc_kw_r   <= '0;
      sc_kh_r   <= '0;
      sc_idx_r  <= '0;
    end else if (cmd.rd) begin
      sc_idx_r <= sc_idx_r + PW'(1);
      if (sc_kw_r == ws_m1) begin
        sc_kw_r   <= '0;
        sc_kh_r   <= sc_kh_r + WSW'(1);
        sc_slot_r <= (sc_slot_r == SW'(WINDOW_CAP - 1)) ? '0 : sc_slot_r + SW'(1);
      end else begin
        sc_kw_r <= sc_kw_r + WSW'(1);
      end
    end
  end

  // Line store addresses: slot times row capacity plus column.
  assign wr_addr = AW'(slot_r) * AW'(ROW_CAP) + AW'(col_r);
  assign rd_addr = AW'(sc_slot_r) * AW'(ROW_CAP) + AW'(win_left_r) + AW'(sc_kw_r);

  mpa_ram #(
    .WIDTH (mpa_pkg::SAMPLE_W),
    .DEPTH (ROW_CAP * WINDOW_CAP)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wr_addr),
    .wdata (in_sample),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Compare stage: strict greater-than, seeded by the first sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= sc_idx_r;
    if (rd_vld_r && ((idx_d_r == '0) || ($signed(rd_data) > best_r))) begin
      best_r     <= $signed(rd_data);
      best_pos_r <= idx_d_r;
    end
  end

  // Output register; it frees up when the sink takes the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_max_r <= best_r;
      out_pos_r <= best_pos_r[mpa_pkg::POS_W-1:0];
      out_row_r <= win_row_r;
      out_col_r <= mpa_pkg::RES_COL_W'(win_col_r);
      out_end_r <= win_end_r;
    end
  end

  // Status and outputs.
  assign status.hit       = row_is_hit && col_is_hit;
  assign status.scan_last = (sc_kw_r == ws_m1) && (sc_kh_r == ws_m1);
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_max   = out_max_r;
  assign out_pos   = out_pos_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_end   = out_end_r;

endmodule
